### rtl/tssf_pkg.sv
// Shared types, widths, codes and tables of the train speed supervision block.
// Used by the channel interfaces and by every RTL module; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tssf_pkg;

    // Field widths.
    localparam int FUNC_W  = 2;
    localparam int SPEED_W = 12;
    localparam int ACCEL_W = 16;
    localparam int CMODE_W = 2;
    localparam int PHASE_W = 2;
    localparam int CRIT_W  = 12;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int DMODE_W    = 2;
    localparam int DELAY_W    = 11;
    localparam int RATE_W     = 14;
    localparam int GRADE_W    = 12;
    localparam int JERK_W     = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVING_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCTION_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GRADE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_JERK     = 3'd4;

    localparam logic [DMODE_W-1:0] RST_DRIVING_MODE   = 2'd0;
    localparam logic [DELAY_W-1:0] RST_BRAKE_DELAY    = 11'd448;
    localparam logic [RATE_W-1:0]  RST_REDUCTION_RATE = 14'd2867;
    localparam logic [GRADE_W-1:0] RST_MAX_GRADE      = 12'd960;
    localparam logic [JERK_W-1:0]  RST_BRAKE_JERK     = 14'd3645;

    // Driving mode codes, which select the threshold offsets.
    localparam logic [DMODE_W-1:0] DM_FULL      = 2'd0;
    localparam logic [DMODE_W-1:0] DM_LIMITED   = 2'd1;
    localparam logic [DMODE_W-1:0] DM_FAULT     = 2'd2;
    localparam logic [DMODE_W-1:0] DM_FAULT_ALL = 2'd3;

    // Command codes.
    localparam logic [FUNC_W-1:0] FN_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_START  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_STOP   = 2'd2;

    // Curve mode codes (the unused code behaves as the constant margin).
    localparam logic [CMODE_W-1:0] CM_NONE  = 2'd0;
    localparam logic [CMODE_W-1:0] CM_CURVE = 2'd1;
    localparam logic [CMODE_W-1:0] CM_CONST = 2'd2;

    // Margin datapath widths. Accelerations are in 1/(4096*125) m/s2.
    localparam int A_W    = 23;                // a, t, g, m, s
    localparam int LIN_W  = 24;                // a + t
    localparam int K_W    = 19;                // delay * 250
    localparam int P1_W   = 43;                // lin * delay * 250
    localparam int P2_W   = 44;                // s * s
    localparam int P3_W   = 57;                // lin * delay * 250 * jerk
    localparam int DJ_W   = 31;                // jerk * 78125
    localparam int N_W    = 58;                // numerator before the factor 9
    localparam int REM_W  = 59;                // 9 * N + den / 2
    localparam int DEN_SHIFT = 16;             // den = jerk * 78125 * 2^16
    localparam int FRONT_LAT = 6;              // registered stages before the divider
    localparam int DIV_STEPS = CRIT_W + 1;     // overflow test plus one step per bit
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int A_SCALE     = 125;
    localparam int GRADE_SCALE = 196;
    localparam int DELAY_SCALE = 250;
    localparam int DEN_SCALE   = 78125;
    localparam int SQ_SHIFT    = 8;
    localparam int NUM_SCALE   = 9;

    // Threshold comparisons.
    localparam int OFF_W = 12;
    localparam int TH_W  = 15;

    typedef enum logic [PHASE_W-1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_C = 2'd2,
        PH_D = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [DMODE_W-1:0] driving_mode;
        logic [DELAY_W-1:0] brake_delay;
        logic [RATE_W-1:0]  reduction_rate;
        logic [GRADE_W-1:0] max_grade;
        logic [JERK_W-1:0]  brake_jerk;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic             nonpos;
        logic [REM_W-1:0] rem;
        logic [DJ_W-1:0]  dj;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [CRIT_W-1:0] crit;
    } t_div_rsp;

    typedef struct packed {
        logic               apply;
        logic [FUNC_W-1:0]  func;
        logic [SPEED_W-1:0] speed;
        logic [SPEED_W-1:0] allowed;
        logic [CMODE_W-1:0] curve_mode;
        logic [CRIT_W-1:0]  crit;
        logic [DMODE_W-1:0] driving_mode;
    } t_eval_req;

    typedef struct packed {
        t_phase phase;
        logic   running;
    } t_sup_state;

    typedef struct packed {
        logic signed [OFF_W-1:0] act;
        logic signed [OFF_W-1:0] lct;
        logic signed [OFF_W-1:0] afs;
        logic signed [OFF_W-1:0] lfs;
        logic signed [OFF_W-1:0] afe;
    } t_offsets;

    // Threshold offsets in 1/16 km/h for each driving mode.
    function automatic t_offsets offsets_for(input logic [DMODE_W-1:0] mode);
        t_offsets o;
        case (mode)
            DM_FULL:    o = '{12'sd64, 12'sd80, 12'sd32, 12'sd48, 12'sd0};
            DM_LIMITED: o = '{12'sd32, 12'sd48, 12'sd16, 12'sd32, 12'sd0};
            DM_FAULT:   o = '{12'sd0, 12'sd16, -12'sd1600, -12'sd1600, -12'sd1600};
            default: o = '{-12'sd1600, -12'sd1600, -12'sd1600, -12'sd1600, -12'sd1600};
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

### rtl/tssf_if.sv
// Valid/ready channel interfaces: input items, result items and config writes.
// Depends on tssf_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tssf_in_if;
    logic                                valid;
    logic                                ready;
    logic [tssf_pkg::FUNC_W-1:0]         func;
    logic [tssf_pkg::SPEED_W-1:0]        measured_speed;
    logic [tssf_pkg::SPEED_W-1:0]        allowed_speed;
    logic signed [tssf_pkg::ACCEL_W-1:0] accel;
    logic [tssf_pkg::CMODE_W-1:0]        curve_mode;

    modport source (output valid, func, measured_speed, allowed_speed, accel, curve_mode,
                    input ready);
    modport sink (input valid, func, measured_speed, allowed_speed, accel, curve_mode,
                  output ready);
endinterface

interface tssf_out_if;
    logic                         valid;
    logic                         ready;
    logic [tssf_pkg::PHASE_W-1:0] phase;
    logic                         emergency_brake;
    logic                         service_brake;
    logic                         traction_cut;
    logic [tssf_pkg::CRIT_W-1:0]  margin_speed;
    logic                         active;

    modport source (output valid, phase, emergency_brake, service_brake, traction_cut,
                    margin_speed, active, input ready);
    modport sink (input valid, phase, emergency_brake, service_brake, traction_cut,
                  margin_speed, active, output ready);
endinterface

interface tssf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tssf_pkg::CFG_IDX_W-1:0]  index;
    logic [tssf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/train_speed_supervision_fsm_core.sv
// Top level of the train overspeed supervision block: channels, config, sequencing.
// Depends on tssf_pkg, tssf_if, tssf_margin_front, tssf_serial_div, tssf_phase_fsm.
`timescale 1ns / 1ps
`default_nettype none

// Train overspeed supervision. Every input transaction is a start command, a
// stop command or a speed sample, and each one produces exactly one result
// transaction carrying the phase (A emergency, B service brake, C coast, D
// traction), the three brake and traction commands, the margin speed and the
// running flag. All speeds are in 1/16 km/h. The block works on one item at
// a time. A speed sample taken while supervision runs, with a curve mode
// other than "no margin", goes from acceptance through a launch register, six
// registered multiply stages that form the margin fraction, the bit-serial
// divider (an overflow test and then one quotient bit per cycle), and then
// handover, event evaluation and result write until the input is ready again.
// Commands and all other samples skip the divider. The result sits in an output
// register, so the next transaction is accepted while a result waits; the
// block only holds an item back in its final cycle if the previous result
// has still not been taken. Configuration writes are accepted in every cycle
// out of reset and are expected only while no item is in flight; neither
// input channel accepts anything while reset is held, and there is no
// clearing pass after reset.

module train_speed_supervision_fsm_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tssf_in_if.sink     i_in,
    tssf_out_if.source  o_out,
    tssf_cfg_if.sink    i_cfg
);

    // Configuration registers, reset to their documented defaults.
    tssf_pkg::t_cfg r_cfg;

    // Captured input item.
    logic [tssf_pkg::FUNC_W-1:0]         r_func;
    logic [tssf_pkg::SPEED_W-1:0]        r_speed;
    logic [tssf_pkg::SPEED_W-1:0]        r_allowed;
    logic signed [tssf_pkg::ACCEL_W-1:0] r_accel;
    logic [tssf_pkg::CMODE_W-1:0]        r_cmode;
    logic [tssf_pkg::CRIT_W-1:0]         r_crit;

    // Sequencer.
    tssf_pkg::t_state r_state;
    tssf_pkg::t_state n_state;
    logic             r_kick;

    // Output register.
    logic                         r_out_valid;
    logic [tssf_pkg::PHASE_W-1:0] r_out_phase;
    logic                         r_out_emerg;
    logic                         r_out_service;
    logic                         r_out_traction;
    logic [tssf_pkg::CRIT_W-1:0]  r_out_margin;
    logic                         r_out_active;

    logic in_accept;
    logic in_ready;
    logic needs_calc;
    logic apply;

    tssf_pkg::t_div_req   div_req;
    tssf_pkg::t_div_rsp   div_rsp;
    tssf_pkg::t_eval_req  eval_req;
    tssf_pkg::t_sup_state sup_state;
    tssf_pkg::t_sup_state sup_next;

    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = in_ready;
    assign in_accept   = i_in.valid & in_ready;

    // A sample needs the margin datapath only while supervision runs and a
    // margin is asked for; everything else goes straight to evaluation.
    assign needs_calc = (i_in.func == tssf_pkg::FN_SAMPLE) && sup_state.running
                        && (i_in.curve_mode != tssf_pkg::CM_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.driving_mode   <= tssf_pkg::RST_DRIVING_MODE;
            r_cfg.brake_delay    <= tssf_pkg::RST_BRAKE_DELAY;
            r_cfg.reduction_rate <= tssf_pkg::RST_REDUCTION_RATE;
            r_cfg.max_grade      <= tssf_pkg::RST_MAX_GRADE;
            r_cfg.brake_jerk     <= tssf_pkg::RST_BRAKE_JERK;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tssf_pkg::CFG_DRIVING_MODE:
                    r_cfg.driving_mode <= i_cfg.data[tssf_pkg::DMODE_W-1:0];
                tssf_pkg::CFG_BRAKE_DELAY:
                    r_cfg.brake_delay <= i_cfg.data[tssf_pkg::DELAY_W-1:0];
                tssf_pkg::CFG_REDUCTION_RATE:
                    r_cfg.reduction_rate <= i_cfg.data[tssf_pkg::RATE_W-1:0];
                tssf_pkg::CFG_MAX_GRADE:
                    r_cfg.max_grade <= i_cfg.data[tssf_pkg::GRADE_W-1:0];
                tssf_pkg::CFG_BRAKE_JERK:
                    r_cfg.brake_jerk <= i_cfg.data[tssf_pkg::JERK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tssf_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = needs_calc ? tssf_pkg::ST_CALC : tssf_pkg::ST_DONE;
                end
            end
            tssf_pkg::ST_CALC: begin
                if (div_rsp.done) begin
                    n_state = tssf_pkg::ST_DONE;
                end
            end
            tssf_pkg::ST_DONE: begin
                if (apply) begin
                    n_state = tssf_pkg::ST_IDLE;
                end
            end
            default: n_state = tssf_pkg::ST_IDLE;
        endcase
    end

    // Output logic of the sequencer. The phase update and the result write
    // happen together, once the output register has room.
    always_comb begin
        in_ready = 1'b0;
        apply    = 1'b0;
        case (r_state)
            tssf_pkg::ST_IDLE: in_ready = i_rst_n;
            tssf_pkg::ST_DONE: apply    = ~r_out_valid | o_out.ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tssf_pkg::ST_IDLE;
            r_kick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= in_accept & needs_calc;
        end
    end

    // The item is held for the whole computation; the margin defaults to zero
    // and is replaced by the divider result when there is one.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func    <= i_in.func;
            r_speed   <= i_in.measured_speed;
            r_allowed <= i_in.allowed_speed;
            r_accel   <= i_in.accel;
            r_cmode   <= i_in.curve_mode;
            r_crit    <= '0;
        end else if (r_state == tssf_pkg::ST_CALC && div_rsp.done) begin
            r_crit <= div_rsp.crit;
        end
    end

    tssf_margin_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_kick),
        .i_accel      (r_accel),
        .i_curve_mode (r_cmode),
        .i_cfg        (r_cfg),
        .o_req        (div_req)
    );

    tssf_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign eval_req.apply        = apply;
    assign eval_req.func         = r_func;
    assign eval_req.speed        = r_speed;
    assign eval_req.allowed      = r_allowed;
    assign eval_req.curve_mode   = r_cmode;
    assign eval_req.crit         = r_crit;
    assign eval_req.driving_mode = r_cfg.driving_mode;

    tssf_phase_fsm u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (eval_req),
        .o_state (sup_state),
        .o_next  (sup_next)
    );

    // Result register. The brake and traction commands follow the new phase
    // and are forced off while supervision is stopped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= apply | (r_out_valid & ~o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_out_phase    <= sup_next.phase;
            r_out_emerg    <= sup_next.running && (sup_next.phase == tssf_pkg::PH_A);
            r_out_service  <= sup_next.running
                              && (sup_next.phase inside {tssf_pkg::PH_A, tssf_pkg::PH_B});
            r_out_traction <= sup_next.running && (sup_next.phase != tssf_pkg::PH_D);
            r_out_margin   <= r_crit;
            r_out_active   <= sup_next.running;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.phase           = r_out_phase;
    assign o_out.emergency_brake = r_out_emerg;
    assign o_out.service_brake   = r_out_service;
    assign o_out.traction_cut    = r_out_traction;
    assign o_out.margin_speed    = r_out_margin;
    assign o_out.active          = r_out_active;

endmodule

`default_nettype wire

### rtl/tssf_margin_front.sv
// Registered multiply chain that forms the margin numerator and denominator.
// Depends on tssf_pkg; feeds tssf_serial_div.
`timescale 1ns / 1ps
`default_nettype none

module tssf_margin_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [tssf_pkg::ACCEL_W-1:0] i_accel,
    input  wire logic [tssf_pkg::CMODE_W-1:0]        i_curve_mode,
    input  wire tssf_pkg::t_cfg                      i_cfg,
    output tssf_pkg::t_div_req                       o_req
);

    // Inputs stay stable while a sample is worked on; configuration must too (a
    // user duty, unenforced); stages recompute in turn, valid tracking them.
    logic [tssf_pkg::FRONT_LAT-1:0]             r_vld;
    logic signed [tssf_pkg::A_W-1:0]            r_a, r_t, r_g, r_s;
    logic [tssf_pkg::K_W-1:0]                   r_k;
    logic                                       r_curve;
    logic signed [tssf_pkg::LIN_W-1:0]          r_lin;
    logic signed [tssf_pkg::P1_W-1:0]           r_p1;
    logic [tssf_pkg::P2_W-1:0]                  r_p2;
    logic [tssf_pkg::DJ_W-1:0]                  r_dj;
    logic signed [tssf_pkg::P3_W-1:0]           r_p3;
    logic signed [tssf_pkg::N_W-1:0]            r_n;
    logic [tssf_pkg::REM_W-1:0]                 r_rem;
    logic                                       r_nonpos;

    logic [tssf_pkg::JERK_W-1:0]                jerk;
    logic signed [tssf_pkg::A_W-1:0]            m;
    logic signed [tssf_pkg::P2_W:0]             sq;
    logic signed [tssf_pkg::N_W+3:0]            num;

    always_comb begin
        jerk = (i_cfg.brake_jerk == '0) ? tssf_pkg::JERK_W'(1) : i_cfg.brake_jerk;
        m    = (r_a < r_g) ? r_a : r_g;
        sq   = (tssf_pkg::P2_W+1)'(r_s) * (tssf_pkg::P2_W+1)'(r_s);
        num  = (tssf_pkg::N_W+4)'(r_n) * (tssf_pkg::N_W+4)'(tssf_pkg::NUM_SCALE)
             + (tssf_pkg::N_W+4)'(signed'({1'b0, r_dj, {(tssf_pkg::DEN_SHIFT-1){1'b0}}}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[tssf_pkg::FRONT_LAT-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        // Stage 1: scale the inputs.
        r_a <= tssf_pkg::A_W'(i_accel) * tssf_pkg::A_W'(tssf_pkg::A_SCALE);
        r_t <= tssf_pkg::A_W'(signed'({1'b0, i_cfg.reduction_rate}))
             * tssf_pkg::A_W'(tssf_pkg::A_SCALE);
        r_g <= -(tssf_pkg::A_W'(signed'({1'b0, i_cfg.max_grade}))
             * tssf_pkg::A_W'(tssf_pkg::GRADE_SCALE));
        r_k <= tssf_pkg::K_W'(i_cfg.brake_delay) * tssf_pkg::K_W'(tssf_pkg::DELAY_SCALE);
        r_curve <= (i_curve_mode == tssf_pkg::CM_CURVE);
        // Stage 2: worst-case deceleration and the linear term.
        r_s   <= r_curve ? m + r_t : m;
        r_lin <= r_curve ? tssf_pkg::LIN_W'(r_a) + tssf_pkg::LIN_W'(r_t)
                         : tssf_pkg::LIN_W'(r_a);
        // Stage 3: first products.
        r_p1 <= tssf_pkg::P1_W'(r_lin) * tssf_pkg::P1_W'(signed'({1'b0, r_k}));
        r_p2 <= sq[tssf_pkg::P2_W-1:0];
        r_dj <= tssf_pkg::DJ_W'(jerk) * tssf_pkg::DJ_W'(tssf_pkg::DEN_SCALE);
        // Stage 4: bring the linear term over the common denominator.
        r_p3 <= tssf_pkg::P3_W'(r_p1) * tssf_pkg::P3_W'(signed'({1'b0, jerk}));
        // Stage 5: numerator.
        r_n <= tssf_pkg::N_W'(r_p3)
             + tssf_pkg::N_W'(signed'({1'b0, r_p2, {tssf_pkg::SQ_SHIFT{1'b0}}}));
        // Stage 6: scaled numerator with the rounding half added.
        r_rem    <= num[tssf_pkg::REM_W-1:0];
        r_nonpos <= (r_n <= 0);
    end

    assign o_req.valid  = r_vld[tssf_pkg::FRONT_LAT-1];
    assign o_req.nonpos = r_nonpos;
    assign o_req.rem    = r_rem;
    assign o_req.dj     = r_dj;

endmodule

`default_nettype wire

### rtl/tssf_serial_div.sv
// Bit-serial restoring divider that turns the margin fraction into a saturated speed.
// Depends on tssf_pkg; driven by tssf_margin_front.
`timescale 1ns / 1ps
`default_nettype none

module tssf_serial_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tssf_pkg::t_div_req i_req,
    output tssf_pkg::t_div_rsp      o_rsp
);

    logic [tssf_pkg::REM_W-1:0]  r_rem;
    logic [tssf_pkg::REM_W-1:0]  r_dv;
    logic [tssf_pkg::CRIT_W-1:0] r_q;
    logic                        r_sat;
    logic                        r_zero;
    logic                        r_busy;
    logic                        r_done;
    logic [tssf_pkg::STEP_W-1:0] r_step;

    logic [tssf_pkg::REM_W:0]    diff;
    logic                        ge;

    always_comb begin
        diff = {1'b0, r_rem} - {1'b0, r_dv};
        ge   = ~diff[tssf_pkg::REM_W];
    end

    // The divisor shift register starts at den * 2^12; the first step only
    // tests for overflow, the next twelve shift one quotient bit in each.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.valid) begin
                r_rem  <= i_req.rem;
                r_dv   <= tssf_pkg::REM_W'(i_req.dj) << (tssf_pkg::DEN_SHIFT + tssf_pkg::CRIT_W);
                r_q    <= '0;
                r_sat  <= 1'b0;
                r_zero <= i_req.nonpos;
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_sat <= ge;
                end else begin
                    if (ge) begin
                        r_rem <= diff[tssf_pkg::REM_W-1:0];
                    end
                    r_q <= {r_q[tssf_pkg::CRIT_W-2:0], ge};
                end
                r_dv   <= r_dv >> 1;
                r_step <= r_step + 1'b1;
                if (r_step == tssf_pkg::STEP_W'(tssf_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.crit = r_zero ? '0 : (r_sat ? '1 : r_q);

endmodule

`default_nettype wire

### rtl/tssf_phase_fsm.sv
// Supervision phase register and the six ordered threshold events.
// Depends on tssf_pkg for codes, offsets and types.
`timescale 1ns / 1ps
`default_nettype none

module tssf_phase_fsm (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tssf_pkg::t_eval_req i_req,
    output tssf_pkg::t_sup_state     o_state,
    output tssf_pkg::t_sup_state     o_next
);

    tssf_pkg::t_sup_state r_state;
    tssf_pkg::t_sup_state n_state;

    tssf_pkg::t_offsets          off;
    logic signed [tssf_pkg::TH_W-1:0] sv, sal, sc;
    logic                        u;
    logic                        e1, e2, e3, e4, e5, e6;

    function automatic logic above(input logic signed [tssf_pkg::TH_W-1:0] lhs,
                                   input logic signed [tssf_pkg::TH_W-1:0] rhs);
        return lhs > rhs;
    endfunction

    always_comb begin
        off = tssf_pkg::offsets_for(i_req.driving_mode);
        sv  = signed'(tssf_pkg::TH_W'(i_req.speed));
        sal = signed'(tssf_pkg::TH_W'(i_req.allowed));
        sc  = signed'(tssf_pkg::TH_W'(i_req.crit));
        u   = (i_req.curve_mode != tssf_pkg::CM_NONE);

        e1 = (i_req.speed == '0);
        e2 = above(sv + tssf_pkg::TH_W'(off.afe), sal)
           || (u && above(sv + tssf_pkg::TH_W'(off.afe) + sc, sal));
        e3 = (!above(sv + tssf_pkg::TH_W'(off.lfs), sal) && !u)
           || !above(sv + tssf_pkg::TH_W'(off.lfs) + sc, sal);
        e4 = above(sv + tssf_pkg::TH_W'(off.afs), sal)
           || (u && above(sv + tssf_pkg::TH_W'(off.afs) + sc, sal));
        e5 = (!above(sv + tssf_pkg::TH_W'(off.lct), sal) && !u)
           || !above(sv + tssf_pkg::TH_W'(off.lct) + sc, sal);
        e6 = above(sv + tssf_pkg::TH_W'(off.act), sal)
           || (u && above(sv + tssf_pkg::TH_W'(off.act) + sc, sal));
    end

    // Each event sees the phase left by the one before it.
    always_comb begin
        n_state = r_state;
        case (i_req.func)
            tssf_pkg::FN_START: begin
                n_state.running = 1'b1;
                n_state.phase   = tssf_pkg::PH_A;
            end
            tssf_pkg::FN_STOP: begin
                n_state.running = 1'b0;
                n_state.phase   = tssf_pkg::PH_A;
            end
            tssf_pkg::FN_SAMPLE: begin
                if (r_state.running) begin
                    if (e1 && n_state.phase == tssf_pkg::PH_A) n_state.phase = tssf_pkg::PH_B;
                    if (e2 && n_state.phase == tssf_pkg::PH_B) n_state.phase = tssf_pkg::PH_A;
                    if (e3 && n_state.phase == tssf_pkg::PH_B) n_state.phase = tssf_pkg::PH_C;
                    if (e4 && n_state.phase == tssf_pkg::PH_C) n_state.phase = tssf_pkg::PH_B;
                    if (e5 && n_state.phase == tssf_pkg::PH_C) n_state.phase = tssf_pkg::PH_D;
                    if (e6 && n_state.phase == tssf_pkg::PH_D) n_state.phase = tssf_pkg::PH_C;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase   <= tssf_pkg::PH_A;
            r_state.running <= 1'b0;
        end else if (i_req.apply) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;
    assign o_next  = n_state;

endmodule

`default_nettype wire
